>>> hw/rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the config text tokenizer
// Item and result layouts, result kinds, punctuation codes and characters.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // characters kept per token are limited by the token buffer size
  localparam int TokenBufferChars = 128;
  localparam int KeepLimitInt     = ((TokenBufferChars - 1) < 127) ?
                                    (TokenBufferChars - 1) : 127;
  localparam logic [6:0] KeepLimit = 7'(KeepLimitInt);

  // results caused by one item, at most
  localparam int MaxResults = 4;
  localparam int SlotIdxW   = $clog2(MaxResults);
  localparam int SlotCntW   = $clog2(MaxResults + 1);

  // depth of the queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  // result kinds
  localparam logic [2:0] KindIdChar  = 3'd0;
  localparam logic [2:0] KindDigChar = 3'd1;
  localparam logic [2:0] KindIdEnd   = 3'd2;
  localparam logic [2:0] KindNumEnd  = 3'd3;
  localparam logic [2:0] KindPunct   = 3'd4;
  localparam logic [2:0] KindUnknown = 3'd5;
  localparam logic [2:0] KindInEnd   = 3'd6;

  // punctuation codes
  localparam logic [3:0] PunctEquals = 4'd0;
  localparam logic [3:0] PunctPeriod = 4'd1;
  localparam logic [3:0] PunctComma  = 4'd2;
  localparam logic [3:0] PunctLBrack = 4'd3;
  localparam logic [3:0] PunctRBrack = 4'd4;
  localparam logic [3:0] PunctSemi   = 4'd5;
  localparam logic [3:0] PunctLBrace = 4'd6;
  localparam logic [3:0] PunctRBrace = 4'd7;
  localparam logic [3:0] PunctPound  = 4'd8;

  // characters
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharUnder   = 8'h5F;
  localparam logic [7:0] CharEquals  = 8'h3D;
  localparam logic [7:0] CharPeriod  = 8'h2E;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharLBrack  = 8'h5B;
  localparam logic [7:0] CharRBrack  = 8'h5D;
  localparam logic [7:0] CharSemi    = 8'h3B;
  localparam logic [7:0] CharLBrace  = 8'h7B;
  localparam logic [7:0] CharRBrace  = 8'h7D;
  localparam logic [7:0] CharPound   = 8'h23;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] punct_code;
    logic [7:0] char_value;
    logic       first_of_token;
    logic [6:0] token_length;
    logic       too_long;
    logic       last_result;
  } result_t;

  // all results of one item, the last one flagged
  typedef struct packed {
    result_t [MaxResults-1:0] slot;
  } bundle_t;

endpackage

>>> hw/rtl/ctt_front.sv
// ----------------------------------------------------------------------------
// ctt_front: scanner of the config text tokenizer
// Takes one byte per cycle while accept_i is high, tracks the scan mode and
// builds the bundle of results the byte causes.
// ----------------------------------------------------------------------------
module ctt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ctt_pkg::item_t   item_i,
  output logic             bundle_push_o,
  output ctt_pkg::bundle_t bundle_o
);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeIdent   = 3'd1;
  localparam logic [2:0] ModeNumber  = 3'd2;
  localparam logic [2:0] ModeSlash   = 3'd3;
  localparam logic [2:0] ModeComment = 3'd4;

  logic [2:0] mode_q, mode_d;
  logic [6:0] cnt_q, cnt_d;
  logic       ovf_q, ovf_d;

  function automatic ctt_pkg::result_t mk_res(logic [2:0] kind, logic [3:0] pc,
                                              logic [7:0] ch, logic first,
                                              logic [6:0] len, logic tl);
    ctt_pkg::result_t r;
    r.kind           = kind;
    r.punct_code     = pc;
    r.char_value     = ch;
    r.first_of_token = first;
    r.token_length   = len;
    r.too_long       = tl;
    r.last_result    = 1'b0;
    return r;
  endfunction

  function automatic ctt_pkg::bundle_t append(ctt_pkg::bundle_t b,
                                              logic [ctt_pkg::SlotCntW-1:0] n,
                                              ctt_pkg::result_t r);
    ctt_pkg::bundle_t o;
    o = b;
    if (n < ctt_pkg::SlotCntW'(ctt_pkg::MaxResults)) begin
      o.slot[n[ctt_pkg::SlotIdxW-1:0]] = r;
    end
    return o;
  endfunction

  // {hit, code}
  function automatic logic [4:0] punct_of(logic [7:0] c);
    logic [4:0] p;
    case (c)
      ctt_pkg::CharEquals: p = {1'b1, ctt_pkg::PunctEquals};
      ctt_pkg::CharPeriod: p = {1'b1, ctt_pkg::PunctPeriod};
      ctt_pkg::CharComma:  p = {1'b1, ctt_pkg::PunctComma};
      ctt_pkg::CharLBrack: p = {1'b1, ctt_pkg::PunctLBrack};
      ctt_pkg::CharRBrack: p = {1'b1, ctt_pkg::PunctRBrack};
      ctt_pkg::CharSemi:   p = {1'b1, ctt_pkg::PunctSemi};
      ctt_pkg::CharLBrace: p = {1'b1, ctt_pkg::PunctLBrace};
      ctt_pkg::CharRBrace: p = {1'b1, ctt_pkg::PunctRBrace};
      ctt_pkg::CharPound:  p = {1'b1, ctt_pkg::PunctPound};
      default:             p = 5'd0;
    endcase
    return p;
  endfunction

  logic [7:0]                   c;
  logic                         fin;
  logic                         c_lower, c_digit, c_space;
  logic                         leave, rescan, keep;
  logic [2:0]                   keep_kind;
  logic [4:0]                   pinfo;
  logic [ctt_pkg::SlotCntW-1:0] n;
  ctt_pkg::bundle_t             b;

  assign c       = item_i.text_byte;
  assign fin     = item_i.final_byte;
  assign c_lower = (c >= 8'h61) && (c <= 8'h7A);
  assign c_digit = (c >= 8'h30) && (c <= 8'h39);
  assign c_space = (c == ctt_pkg::CharSpace) || (c == ctt_pkg::CharTab) ||
                   (c == ctt_pkg::CharNewline);
  assign pinfo   = punct_of(c);

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    b         = '0;
    n         = '0;
    leave     = 1'b0;
    rescan    = 1'b0;
    keep      = 1'b0;
    keep_kind = ctt_pkg::KindIdChar;

    case (mode_q)
      ModeIdent: begin
        if (c_lower || c_digit || (c == ctt_pkg::CharUnder)) begin
          keep = 1'b1;
        end else begin
          leave = 1'b1;
        end
      end
      ModeNumber: begin
        if (c_digit) begin
          keep      = 1'b1;
          keep_kind = ctt_pkg::KindDigChar;
        end else begin
          leave = 1'b1;
        end
      end
      ModeSlash: begin
        if (c == ctt_pkg::CharSlash) begin
          mode_d = ModeComment;
        end else begin
          leave = 1'b1;
        end
      end
      ModeComment: begin
        if (c == ctt_pkg::CharNewline) begin
          mode_d = ModeIdle;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // close whatever the old mode had open
    if (leave) begin
      case (mode_q)
        ModeIdent: begin
          b = append(b, n, mk_res(ctt_pkg::KindIdEnd, 4'd0, 8'd0, 1'b0, cnt_q, ovf_q));
          n = n + 1'b1;
        end
        ModeNumber: begin
          b = append(b, n, mk_res(ctt_pkg::KindNumEnd, 4'd0, 8'd0, 1'b0, cnt_q, ovf_q));
          n = n + 1'b1;
        end
        ModeSlash: begin
          b = append(b, n, mk_res(ctt_pkg::KindUnknown, 4'd0, ctt_pkg::CharSlash,
                                  1'b0, 7'd0, 1'b0));
          n = n + 1'b1;
        end
        default: begin
        end
      endcase
      mode_d = ModeIdle;
      cnt_d  = '0;
      ovf_d  = 1'b0;
      rescan = 1'b1;
    end

    // scan from idle
    if (rescan) begin
      mode_d = ModeIdle;
      if (c_space) begin
      end else if (c == ctt_pkg::CharSlash) begin
        mode_d = ModeSlash;
      end else if (c_lower) begin
        mode_d    = ModeIdent;
        cnt_d     = '0;
        ovf_d     = 1'b0;
        keep      = 1'b1;
        keep_kind = ctt_pkg::KindIdChar;
      end else if (c_digit) begin
        mode_d    = ModeNumber;
        cnt_d     = '0;
        ovf_d     = 1'b0;
        keep      = 1'b1;
        keep_kind = ctt_pkg::KindDigChar;
      end else if (pinfo[4]) begin
        b = append(b, n, mk_res(ctt_pkg::KindPunct, pinfo[3:0], 8'd0, 1'b0, 7'd0, 1'b0));
        n = n + 1'b1;
      end else begin
        b = append(b, n, mk_res(ctt_pkg::KindUnknown, 4'd0, c, 1'b0, 7'd0, 1'b0));
        n = n + 1'b1;
      end
    end

    // characters past the keep limit are dropped
    if (keep) begin
      if (cnt_d < ctt_pkg::KeepLimit) begin
        b = append(b, n, mk_res(keep_kind, 4'd0, c, (cnt_d == 7'd0), 7'd0, 1'b0));
        n = n + 1'b1;
        cnt_d = cnt_d + 7'd1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    // final byte closes everything and returns to reset state
    if (fin) begin
      case (mode_d)
        ModeIdent: begin
          b = append(b, n, mk_res(ctt_pkg::KindIdEnd, 4'd0, 8'd0, 1'b0, cnt_d, ovf_d));
          n = n + 1'b1;
        end
        ModeNumber: begin
          b = append(b, n, mk_res(ctt_pkg::KindNumEnd, 4'd0, 8'd0, 1'b0, cnt_d, ovf_d));
          n = n + 1'b1;
        end
        ModeSlash: begin
          b = append(b, n, mk_res(ctt_pkg::KindUnknown, 4'd0, ctt_pkg::CharSlash,
                                  1'b0, 7'd0, 1'b0));
          n = n + 1'b1;
        end
        default: begin
        end
      endcase
      b = append(b, n, mk_res(ctt_pkg::KindInEnd, 4'd0, 8'd0, 1'b0, 7'd0, 1'b0));
      n = n + 1'b1;
      mode_d = ModeIdle;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end

    if (n != '0) begin
      b.slot[ctt_pkg::SlotIdxW'(n - 1'b1)].last_result = 1'b1;
    end
  end

  assign bundle_o      = b;
  assign bundle_push_o = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

>>> hw/rtl/ctt_fifo.sv
// ----------------------------------------------------------------------------
// ctt_fifo: result bundle queue of the config text tokenizer
// Holds the bundles built by the scanner until the back end unloads them.
// ----------------------------------------------------------------------------
module ctt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ctt_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ctt_pkg::bundle_t data_o
);

  ctt_pkg::bundle_t              mem_q [ctt_pkg::FifoDepth];
  logic [ctt_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [ctt_pkg::FifoPtrW:0]    count_q;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == (ctt_pkg::FifoPtrW + 1)'(ctt_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ctt_back.sv
// ----------------------------------------------------------------------------
// ctt_back: result serializer of the config text tokenizer
// Unloads the head bundle, one result per cycle while out_q is free or popped.
// ----------------------------------------------------------------------------
module ctt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_empty_i,
  input  ctt_pkg::bundle_t fifo_data_i,
  output logic             fifo_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ctt_pkg::result_t result_o
);

  ctt_pkg::result_t              out_q;
  logic                          out_vld_q;
  logic [ctt_pkg::SlotIdxW-1:0]  idx_q;
  ctt_pkg::result_t              head;
  logic                          load;

  assign head       = fifo_data_i.slot[idx_q];
  // a queued result refills the output register when empty or taken this cycle
  assign load       = !fifo_empty_i && (!out_vld_q || pop_i);
  assign fifo_pop_o = load && head.last_result;
  assign empty_o    = !out_vld_q;
  assign result_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= head.last_result ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/config_text_tokenizer.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer: streaming tokenizer for configuration text
// Skips blanks and line comments and reports identifiers, numbers,
// punctuation and unknown characters as a stream of results.
// ----------------------------------------------------------------------------
// Usage:
// - input queue: drive item_i and raise push; a byte is taken at a clock
//   edge where push is high and full is low. One byte per cycle is taken
//   as long as the result queue has room.
// - result queue: while empty is low, result_o holds the oldest result;
//   raise pop to take it. One result leaves per cycle while results wait.
// - a byte causes zero to four results. They pass through the bundle queue
//   and the output register before showing on result_o, then follow one
//   per cycle while pop is high; the single output port sets the rate
//   when bytes cause several results.
// - between scanner and output sits a four-bundle queue: when pop stays
//   low the scanner keeps taking bytes until that queue fills, then full
//   rises. Bytes causing no result never enter the queue.
// - reset puts the scanner between tokens with no count and empties both
//   the queue and the output register. No configuration is needed.
// ----------------------------------------------------------------------------
module config_text_tokenizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  ctt_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output ctt_pkg::result_t result_o
);

  logic             accept;
  logic             bundle_push, bundle_full, bundle_pop, bundle_empty;
  ctt_pkg::bundle_t bundle_in, bundle_head;

  assign full   = bundle_full;
  assign accept = push && !bundle_full;

  ctt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item_i),
    .bundle_push_o (bundle_push),
    .bundle_o      (bundle_in)
  );

  ctt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bundle_push),
    .data_i  (bundle_in),
    .full_o  (bundle_full),
    .pop_i   (bundle_pop),
    .empty_o (bundle_empty),
    .data_o  (bundle_head)
  );

  ctt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (bundle_empty),
    .fifo_data_i  (bundle_head),
    .fifo_pop_o   (bundle_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result_o)
  );

`ifndef SYNTHESIS
  // input end always closes the results of its byte
  a_inend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.kind == ctt_pkg::KindInEnd)) |-> result_o.last_result)
    else $error("input end result without last flag");

  // a closed token kept at least its first character
  a_end_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((result_o.kind == ctt_pkg::KindIdEnd) ||
                (result_o.kind == ctt_pkg::KindNumEnd)))
    |-> (result_o.token_length != 7'd0))
    else $error("token end with zero length");

  a_too_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.too_long) |-> (result_o.token_length == ctt_pkg::KeepLimit))
    else $error("too long token not at keep limit");

  a_first_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.first_of_token)
    |-> ((result_o.kind == ctt_pkg::KindIdChar) ||
         (result_o.kind == ctt_pkg::KindDigChar)))
    else $error("first mark on a non-character result");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the config text tokenizer
// Feeds directed text, an overlong token and random token streams through the
// push/full side, predicts results in a local scanner model or typed row, checks
// each popped result in order, under four sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumDirRows  = 26;
  localparam int PhaseBytes  = 18;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 10;
  localparam int MaxErrLines = 40;

  localparam logic [8:0][7:0] PunctChars = {
    ctt_pkg::CharPound, ctt_pkg::CharRBrace, ctt_pkg::CharLBrace,
    ctt_pkg::CharSemi, ctt_pkg::CharRBrack, ctt_pkg::CharLBrack,
    ctt_pkg::CharComma, ctt_pkg::CharPeriod, ctt_pkg::CharEquals};
  localparam logic [2:0][7:0] BlankChars = {
    ctt_pkg::CharNewline, ctt_pkg::CharTab, ctt_pkg::CharSpace};

  typedef enum logic [2:0] {
    ScanIdle,
    ScanIdent,
    ScanNumber,
    ScanSlash,
    ScanComment
  } scan_mode_e;

  typedef struct packed {
    logic [7:0]       ch;
    logic             fin;
    logic             typed;
    ctt_pkg::result_t want;
  } dir_row_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push   = 1'b0;
  logic             pop    = 1'b0;
  logic             full;
  logic             empty;
  ctt_pkg::item_t   item_i = '0;
  ctt_pkg::result_t result_o;

  // scanner model state
  scan_mode_e       scan_q    = ScanIdle;
  logic [6:0]       kept_q    = '0;
  logic             dropped_q = 1'b0;
  ctt_pkg::result_t byte_res[$];
  ctt_pkg::result_t expected_res[$];

  dir_row_t dir_rows [NumDirRows];
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int cycle_count   = 0;

  config_text_tokenizer dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .item_i,
    .empty,
    .pop,
    .result_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic is_lower(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic ctt_pkg::result_t solo(input logic [2:0] kind,
                                            input logic [3:0] code,
                                            input logic [7:0] ch, input logic first);
    ctt_pkg::result_t r;
    r = '0;
    r.kind           = kind;
    r.punct_code     = code;
    r.char_value     = ch;
    r.first_of_token = first;
    r.last_result    = 1'b1;
    return r;
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [3:0] code,
                                     input logic [7:0] ch, input logic first,
                                     input logic [6:0] len, input logic tl);
    ctt_pkg::result_t r;
    r = '0;
    r.kind           = kind;
    r.punct_code     = code;
    r.char_value     = ch;
    r.first_of_token = first;
    r.token_length   = len;
    r.too_long       = tl;
    if (byte_res.size() < ctt_pkg::MaxResults) byte_res.push_back(r);
  endfunction

  // characters past the keep limit are dropped and mark the token as too long
  function automatic void keep_char(input logic [7:0] c, input logic [2:0] kind);
    if (kept_q < ctt_pkg::KeepLimit) begin
      add_result(kind, '0, c, kept_q == '0, '0, 1'b0);
      kept_q++;
    end else begin
      dropped_q = 1'b1;
    end
  endfunction

  function automatic void close_token();
    case (scan_q)
      ScanIdent:  add_result(ctt_pkg::KindIdEnd, '0, '0, 1'b0, kept_q, dropped_q);
      ScanNumber: add_result(ctt_pkg::KindNumEnd, '0, '0, 1'b0, kept_q, dropped_q);
      ScanSlash:  add_result(ctt_pkg::KindUnknown, '0, ctt_pkg::CharSlash, 1'b0, '0, 1'b0);
      default: ;
    endcase
    scan_q    = ScanIdle;
    kept_q    = '0;
    dropped_q = 1'b0;
  endfunction

  function automatic int punct_code_of(input logic [7:0] c);
    case (c)
      ctt_pkg::CharEquals: return ctt_pkg::PunctEquals;
      ctt_pkg::CharPeriod: return ctt_pkg::PunctPeriod;
      ctt_pkg::CharComma:  return ctt_pkg::PunctComma;
      ctt_pkg::CharLBrack: return ctt_pkg::PunctLBrack;
      ctt_pkg::CharRBrack: return ctt_pkg::PunctRBrack;
      ctt_pkg::CharSemi:   return ctt_pkg::PunctSemi;
      ctt_pkg::CharLBrace: return ctt_pkg::PunctLBrace;
      ctt_pkg::CharRBrace: return ctt_pkg::PunctRBrace;
      ctt_pkg::CharPound:  return ctt_pkg::PunctPound;
      default:             return -1;
    endcase
  endfunction

  function automatic void scan_between(input logic [7:0] c);
    int code;
    scan_q = ScanIdle;
    code   = punct_code_of(c);
    if (c == ctt_pkg::CharSpace || c == ctt_pkg::CharTab || c == ctt_pkg::CharNewline)
      return;
    if (c == ctt_pkg::CharSlash) begin
      scan_q = ScanSlash;
    end else if (is_lower(c)) begin
      scan_q    = ScanIdent;
      kept_q    = '0;
      dropped_q = 1'b0;
      keep_char(c, ctt_pkg::KindIdChar);
    end else if (is_digit(c)) begin
      scan_q    = ScanNumber;
      kept_q    = '0;
      dropped_q = 1'b0;
      keep_char(c, ctt_pkg::KindDigChar);
    end else if (code >= 0) begin
      add_result(ctt_pkg::KindPunct, 4'(code), '0, 1'b0, '0, 1'b0);
    end else begin
      add_result(ctt_pkg::KindUnknown, '0, c, 1'b0, '0, 1'b0);
    end
  endfunction

  // fills byte_res with the results one text byte causes
  function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
    ctt_pkg::result_t r;
    byte_res.delete();
    case (scan_q)
      ScanIdent: begin
        if (is_lower(c) || is_digit(c) || c == ctt_pkg::CharUnder)
          keep_char(c, ctt_pkg::KindIdChar);
        else begin
          close_token();
          scan_between(c);
        end
      end
      ScanNumber: begin
        if (is_digit(c)) keep_char(c, ctt_pkg::KindDigChar);
        else begin
          close_token();
          scan_between(c);
        end
      end
      ScanSlash: begin
        if (c == ctt_pkg::CharSlash) scan_q = ScanComment;
        else begin
          close_token();
          scan_between(c);
        end
      end
      ScanComment: begin
        if (c == ctt_pkg::CharNewline) scan_q = ScanIdle;
      end
      default: scan_between(c);
    endcase
    if (fin) begin
      // an open comment is simply dropped
      if (scan_q == ScanComment) scan_q = ScanIdle;
      close_token();
      add_result(ctt_pkg::KindInEnd, '0, '0, 1'b0, '0, 1'b0);
    end
    if (byte_res.size() > 0) begin
      r = byte_res.pop_back();
      r.last_result = 1'b1;
      byte_res.push_back(r);
    end
  endfunction

  function automatic logic [7:0] rand_lower();
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_ident_tail();
    case ($urandom_range(3))
      0, 1:    return rand_lower();
      2:       return rand_digit();
      default: return ctt_pkg::CharUnder;
    endcase
  endfunction

  task automatic report_failure(input string msg);
    if (n_errors < MaxErrLines) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic check_result(input ctt_pkg::result_t got, input ctt_pkg::result_t want);
    if (got.kind != want.kind)
      report_failure($sformatf("result %0d kind %0d, expected %0d",
                               n_checked, got.kind, want.kind));
    if (got.punct_code != want.punct_code)
      report_failure($sformatf("result %0d punct_code %0d, expected %0d",
                               n_checked, got.punct_code, want.punct_code));
    if (got.char_value != want.char_value)
      report_failure($sformatf("result %0d char_value %02h, expected %02h",
                               n_checked, got.char_value, want.char_value));
    if (got.first_of_token != want.first_of_token)
      report_failure($sformatf("result %0d first_of_token %0d, expected %0d",
                               n_checked, got.first_of_token, want.first_of_token));
    if (got.token_length != want.token_length)
      report_failure($sformatf("result %0d token_length %0d, expected %0d",
                               n_checked, got.token_length, want.token_length));
    if (got.too_long != want.too_long)
      report_failure($sformatf("result %0d too_long %0d, expected %0d",
                               n_checked, got.too_long, want.too_long));
    if (got.last_result != want.last_result)
      report_failure($sformatf("result %0d last_result %0d, expected %0d",
                               n_checked, got.last_result, want.last_result));
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] ch, input logic fin,
                           input logic typed = 1'b0, input ctt_pkg::result_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= '{text_byte: ch, final_byte: fin};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tokenize_byte(ch, fin);
    if (typed) begin
      byte_res.delete();
      byte_res.push_back(want);
    end
    foreach (byte_res[i]) expected_res.push_back(byte_res[i]);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic rand_send(input logic [7:0] ch);
    send_byte(ch, $urandom_range(39) == 0);
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (expected_res.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_long_token(input logic number, input int len, input logic close_fin);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (number) c = rand_digit();
      else c = (i == 0) ? rand_lower() : rand_ident_tail();
      send_byte(c, close_fin && i == len - 1);
    end
    if (!close_fin) send_byte(ctt_pkg::CharSemi, 1'b0);
  endtask

  task automatic send_chunk();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 30) begin
      len = $urandom_range(10, 1);
      rand_send(rand_lower());
      repeat (len - 1) rand_send(rand_ident_tail());
    end else if (pick < 50) begin
      len = $urandom_range(6, 1);
      repeat (len) rand_send(rand_digit());
    end else if (pick < 65) begin
      rand_send(PunctChars[$urandom_range(8)]);
    end else if (pick < 75) begin
      rand_send(BlankChars[$urandom_range(2)]);
    end else if (pick < 83) begin
      rand_send(ctt_pkg::CharSlash);
      rand_send(ctt_pkg::CharSlash);
      repeat ($urandom_range(6)) rand_send(8'($urandom_range(255)));
      rand_send(ctt_pkg::CharNewline);
    end else if (pick < 88) begin
      // lone slash, the next chunk decides what follows it
      rand_send(ctt_pkg::CharSlash);
    end else begin
      rand_send(8'($urandom_range(255)));
    end
  endtask

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_res.size() == 0) begin
        report_failure($sformatf("result kind %0d char %02h with nothing pending",
                                 result_o.kind, result_o.char_value));
      end else begin
        check_result(result_o, expected_res.pop_front());
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_res.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int start;
    dir_rows = '{
      '{ctt_pkg::CharEquals, 1'b0, 1'b1,
        solo(ctt_pkg::KindPunct, ctt_pkg::PunctEquals, '0, 1'b0)},
      '{ctt_pkg::CharPound,  1'b0, 1'b1,
        solo(ctt_pkg::KindPunct, ctt_pkg::PunctPound, '0, 1'b0)},
      '{ctt_pkg::CharLBrace, 1'b0, 1'b1,
        solo(ctt_pkg::KindPunct, ctt_pkg::PunctLBrace, '0, 1'b0)},
      '{ctt_pkg::CharRBrack, 1'b0, 1'b1,
        solo(ctt_pkg::KindPunct, ctt_pkg::PunctRBrack, '0, 1'b0)},
      '{8'hFF,      1'b0, 1'b1, solo(ctt_pkg::KindUnknown, '0, 8'hFF, 1'b0)},
      '{8'h00,      1'b0, 1'b1, solo(ctt_pkg::KindUnknown, '0, 8'h00, 1'b0)},
      '{"a",        1'b0, 1'b1, solo(ctt_pkg::KindIdChar, '0, "a", 1'b1)},
      '{"z",        1'b0, 1'b0, '0},
      '{ctt_pkg::CharUnder,  1'b0, 1'b0, '0},
      '{"9",        1'b0, 1'b0, '0},
      '{ctt_pkg::CharSpace,  1'b0, 1'b0, '0},
      '{"0",        1'b0, 1'b1, solo(ctt_pkg::KindDigChar, '0, "0", 1'b1)},
      '{ctt_pkg::CharComma,  1'b0, 1'b0, '0},
      '{ctt_pkg::CharSlash,  1'b0, 1'b0, '0},
      '{ctt_pkg::CharLBrack, 1'b0, 1'b0, '0},
      '{ctt_pkg::CharSlash,  1'b0, 1'b0, '0},
      '{ctt_pkg::CharSlash,  1'b0, 1'b0, '0},
      '{"q",        1'b0, 1'b0, '0},
      '{ctt_pkg::CharNewline, 1'b0, 1'b0, '0},
      '{ctt_pkg::CharTab,    1'b0, 1'b0, '0},
      '{ctt_pkg::CharPeriod, 1'b1, 1'b0, '0},
      '{ctt_pkg::CharSlash,  1'b0, 1'b0, '0},
      '{"a",        1'b1, 1'b0, '0},
      '{ctt_pkg::CharSpace,  1'b1, 1'b1, solo(ctt_pkg::KindInEnd, '0, '0, 1'b0)},
      '{"7",        1'b0, 1'b0, '0},
      '{ctt_pkg::CharSemi,   1'b1, 1'b0, '0}
    };
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].fin,
                                     dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          pop_stall_pct = 0;
          send_long_token(1'b0, ctt_pkg::KeepLimitInt + 2, 1'b0);
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 33;
          pop_stall_pct = 33;
        end
      endcase
      start = n_sent;
      while (n_sent - start < PhaseBytes) send_chunk();
      hold_until_drained();
    end

    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d text bytes: directed text, one overlong identifier, random streams",
             n_sent);
    $display("checked %0d results under four idle patterns, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> config_text_tokenizer.f
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_front.sv
hw/rtl/ctt_fifo.sv
hw/rtl/ctt_back.sv
hw/rtl/config_text_tokenizer.sv
dv/tb.sv
